// File: src/s2dec_pkg.sv
// Shared types and constants for the signed integer to decimal text converter.
package s2dec_pkg;

    localparam int MagWidth   = 32;
    localparam int DigitCount = 10;
    localparam int BcdWidth   = 4 * DigitCount;
    localparam int StepWidth  = $clog2(MagWidth);
    localparam int DigitIdxW  = $clog2(DigitCount);

    localparam logic [7:0] CharZero  = 8'h30;
    localparam logic [7:0] CharMinus = 8'h2D;

    typedef struct packed {
        logic load;
        logic shift;
        logic prep;
        logic emit;
    } s2dec_cmd_t;

    typedef struct packed {
        logic shift_done;
        logic next_last;
    } s2dec_sts_t;

endpackage

// File: src/s2dec_dpath.sv
// Datapath: magnitude and BCD registers, shift-add-3 step, digit selection and output register.
module s2dec_dpath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [s2dec_pkg::MagWidth-1:0]      value,
    input  s2dec_pkg::s2dec_cmd_t               cmd,
    output s2dec_pkg::s2dec_sts_t               sts,
    output logic [7:0]                          out_char,
    output logic                                is_last
);

    logic [s2dec_pkg::MagWidth-1:0]  mag_reg, mag_next;
    logic [s2dec_pkg::BcdWidth-1:0]  bcd_reg, bcd_next;
    logic [s2dec_pkg::StepWidth-1:0] cnt_reg, cnt_next;
    logic [s2dec_pkg::DigitIdxW-1:0] dig_reg, dig_next;
    logic                            sign_pend_reg, sign_pend_next;
    logic [7:0]                      out_char_reg, out_char_next;
    logic                            is_last_reg, is_last_next;
    logic [s2dec_pkg::BcdWidth-1:0]  bcd_adj;
    logic [s2dec_pkg::DigitIdxW-1:0] lead;
    logic [3:0]                      cur_digit;

    always_comb
    begin
        for (int i = 0; i < s2dec_pkg::DigitCount; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end
            else
            begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb
    begin
        lead = '0;
        for (int i = 0; i < s2dec_pkg::DigitCount; i++)
        begin
            if (bcd_reg[4*i +: 4] != 4'd0)
            begin
                lead = s2dec_pkg::DigitIdxW'(i);
            end
        end
    end

    assign cur_digit = bcd_reg[4*dig_reg +: 4];

    always_comb
    begin
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        cnt_next       = cnt_reg;
        dig_next       = dig_reg;
        sign_pend_next = sign_pend_reg;
        out_char_next  = out_char_reg;
        is_last_next   = is_last_reg;
        if (cmd.load)
        begin
            mag_next       = value[s2dec_pkg::MagWidth-1] ? (~value + 1'b1) : value;
            bcd_next       = '0;
            cnt_next       = '0;
            sign_pend_next = value[s2dec_pkg::MagWidth-1];
        end
        if (cmd.shift)
        begin
            bcd_next = {bcd_adj[s2dec_pkg::BcdWidth-2:0], mag_reg[s2dec_pkg::MagWidth-1]};
            mag_next = {mag_reg[s2dec_pkg::MagWidth-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
        end
        if (cmd.prep)
        begin
            dig_next = lead;
        end
        if (cmd.emit)
        begin
            if (sign_pend_reg)
            begin
                out_char_next  = s2dec_pkg::CharMinus;
                is_last_next   = 1'b0;
                sign_pend_next = 1'b0;
            end
            else
            begin
                out_char_next = s2dec_pkg::CharZero + {4'd0, cur_digit};
                is_last_next  = (dig_reg == '0);
                dig_next      = dig_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            dig_reg       <= '0;
            sign_pend_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            dig_reg       <= dig_next;
            sign_pend_reg <= sign_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        bcd_reg      <= bcd_next;
        out_char_reg <= out_char_next;
        is_last_reg  <= is_last_next;
    end

    assign sts.shift_done = (cnt_reg == s2dec_pkg::StepWidth'(s2dec_pkg::MagWidth - 1));
    assign sts.next_last  = !sign_pend_reg && (dig_reg == '0);
    assign out_char       = out_char_reg;
    assign is_last        = is_last_reg;

endmodule

// File: src/s2dec_ctrl.sv
// Controller: sequences load, conversion steps, digit pointer set-up and character output.
module s2dec_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output s2dec_pkg::s2dec_cmd_t cmd,
    input  s2dec_pkg::s2dec_sts_t sts
);

    typedef enum logic [1:0] {
        IDLE,
        CONVERT,
        PREP,
        EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = CONVERT;
                end
            end
            CONVERT:
            begin
                cmd.shift = 1'b1;
                if (sts.shift_done)
                begin
                    state_next = PREP;
                end
            end
            PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = EMIT;
            end
            EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit       = 1'b1;
                    out_valid_next = 1'b1;
                    if (sts.next_last)
                    begin
                        state_next = IDLE;
                    end
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == IDLE);
    assign out_valid = out_valid_reg;

    a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("Controller took a request while busy.");

    a_convert_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == CONVERT && sts.shift_done) |=> (state_reg == PREP))
        else $error("Conversion did not finish after its last step.");

    a_emit_space: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || out_ready))
        else $error("Character overwritten before it was taken.");

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.shift, cmd.prep, cmd.emit}))
        else $error("More than one datapath command at once.");

endmodule

// File: src/signed_int_to_decimal_ascii_core.sv
// Top level of the signed 32-bit integer to decimal ASCII text converter.
//
// A request on the input channel (in_valid, in_ready, value) carries one signed
// 32-bit integer. The block answers with its decimal text on the output channel
// (out_valid, out_ready, out_char, is_last), one character per transfer, most
// significant first: a leading '-' for negative values, no leading zeros, and
// is_last set on the final character. The most negative value gives "-2147483648".
// The magnitude is turned into BCD by a shift-add-3 loop of 32 steps, one step a
// cycle; the digit pointer is then set, and the characters follow one a cycle
// while the receiver does not stall. One item is handled at a time; in_ready
// rises once the last character has been loaded into the output register.
// When the receiver stalls, the current character holds and the sequence pauses.
// Reset clears the controller and drops out_valid; nothing is kept between items.
module signed_int_to_decimal_ascii_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic signed [s2dec_pkg::MagWidth-1:0] value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [7:0]                         out_char,
    output logic                               is_last
);

    s2dec_pkg::s2dec_cmd_t cmd;
    s2dec_pkg::s2dec_sts_t sts;

    s2dec_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    s2dec_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .value    (value),
        .cmd      (cmd),
        .sts      (sts),
        .out_char (out_char),
        .is_last  (is_last)
    );

endmodule
